// File: rtl/ekj_pkg.sv
// Shared types, constants and fixed-point helpers for the Euler kinematic Jacobian unit.
// No dependencies; every other file in rtl/ imports this package.
package ekj_pkg;

    localparam int ANGLE_W      = 16;
    localparam int ENTRY_W      = 32;
    localparam int ROW_W        = 3;
    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_W     = 34;
    // Fold register, one register per rotation, output register.
    localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
    localparam int QUOT_BITS    = 33;
    // Prepare register, one register per quotient bit, limit register.
    localparam int DIV_LAT      = QUOT_BITS + 2;
    // Rotation pipeline, product stage, divider pipeline.
    localparam int PIPE_DEPTH   = CORDIC_LAT + 1 + DIV_LAT;
    // Product rows run from the sum stage until they meet the quotients.
    localparam int ROWS_DEPTH   = DIV_LAT - 1;

    localparam logic [ROW_W-1:0] ROW_FIRST = 3'd0;
    localparam logic [ROW_W-1:0] ROW_R1    = 3'd1;
    localparam logic [ROW_W-1:0] ROW_R2    = 3'd2;
    localparam logic [ROW_W-1:0] ROW_TAN   = 3'd3;
    localparam logic [ROW_W-1:0] ROW_RATE  = 3'd4;
    localparam logic [ROW_W-1:0] ROW_SEC   = 3'd5;

    localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 34'sd652032874;
    localparam logic signed [ANGLE_W-1:0]  HALF_PI   = 16'sd16384;
    localparam logic signed [ANGLE_W:0]    FULL_PI   = 17'sd32768;

    localparam logic [29:0] ATAN_TAB [CORDIC_STEPS] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861,
        30'd10430,     30'd5215,      30'd2608,      30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81
    };

    typedef logic signed [ENTRY_W-1:0] entry_t;

    localparam entry_t ONE_Q16  = 32'sd65536;
    localparam entry_t ZERO_Q16 = 32'sd0;

    // Entries of rows 0 to 2 and the computed entries of row 4.
    typedef struct packed {
        entry_t r00, r01, r02;
        entry_t r10, r11, r12;
        entry_t r20, r21, r22;
        entry_t r41, r42;
    } ekj_rows_t;

    // One quotient with its clip flag.
    typedef struct packed {
        entry_t value;
        logic   sat;
    } ekj_quot_t;

    // Q30 by Q30 product, floor-shifted back to Q30.
    function automatic entry_t mul30(input entry_t a, input entry_t b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return p[61:30];
    endfunction

    // Q30 value to Q15.16 with rounding half up.
    function automatic entry_t toq16(input logic signed [CORDIC_W-1:0] v);
        logic signed [CORDIC_W-1:0] t;
        t = v + 34'sd8192;
        return {{12{t[CORDIC_W-1]}}, t[CORDIC_W-1:14]};
    endfunction

endpackage

// File: rtl/ekj_cordic.sv
// Pipelined rotation-mode CORDIC giving sine and cosine in Q2.30 of a binary angle.
// Depends on ekj_pkg for the arctangent table, widths and constants.
module ekj_cordic (
    input  logic                           aclk,
    input  logic                           en,
    input  logic signed [ekj_pkg::ANGLE_W-1:0] angle,
    output ekj_pkg::entry_t                sin_out,
    output ekj_pkg::entry_t                cos_out
);
    import ekj_pkg::*;

    logic signed [CORDIC_W-1:0] x_reg [CORDIC_STEPS+1];
    logic signed [CORDIC_W-1:0] y_reg [CORDIC_STEPS+1];
    logic signed [CORDIC_W-1:0] z_reg [CORDIC_STEPS+1];
    logic [CORDIC_STEPS:0]      neg_reg;
    logic signed [ANGLE_W:0]    fold_next;
    logic                       neg_next;
    entry_t                     sin_reg;
    entry_t                     cos_reg;

    // Fold the angle into the right half plane; the result is negated at the end.
    always_comb begin
        fold_next = {angle[ANGLE_W-1], angle};
        neg_next  = 1'b0;
        if (angle > HALF_PI) begin
            fold_next = {angle[ANGLE_W-1], angle} - FULL_PI;
            neg_next  = 1'b1;
        end else if (angle < -HALF_PI) begin
            fold_next = {angle[ANGLE_W-1], angle} + FULL_PI;
            neg_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]   <= CORDIC_X0;
            y_reg[0]   <= '0;
            z_reg[0]   <= {fold_next[ANGLE_W], fold_next, 16'b0};
            neg_reg[0] <= neg_next;
        end
    end

    // One micro-rotation per stage.
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        logic signed [CORDIC_W-1:0] x_next;
        logic signed [CORDIC_W-1:0] y_next;
        logic signed [CORDIC_W-1:0] z_next;

        always_comb begin
            if (!z_reg[i][CORDIC_W-1]) begin
                x_next = x_reg[i] - (y_reg[i] >>> i);
                y_next = y_reg[i] + (x_reg[i] >>> i);
                z_next = z_reg[i] - $signed({4'b0, ATAN_TAB[i]});
            end else begin
                x_next = x_reg[i] + (y_reg[i] >>> i);
                y_next = y_reg[i] - (x_reg[i] >>> i);
                z_next = z_reg[i] + $signed({4'b0, ATAN_TAB[i]});
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[i+1]   <= x_next;
                y_reg[i+1]   <= y_next;
                z_reg[i+1]   <= z_next;
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    // Undo the fold and register the results.
    always_ff @(posedge aclk) begin
        if (en) begin
            sin_reg <= ENTRY_W'(neg_reg[CORDIC_STEPS] ? -y_reg[CORDIC_STEPS]
                                                      : y_reg[CORDIC_STEPS]);
            cos_reg <= ENTRY_W'(neg_reg[CORDIC_STEPS] ? -x_reg[CORDIC_STEPS]
                                                      : x_reg[CORDIC_STEPS]);
        end
    end

    assign sin_out = sin_reg;
    assign cos_out = cos_reg;

endmodule

// File: rtl/ekj_divider.sv
// Pipelined restoring divider: rounded Q60 / (Q30 * 2^14) quotient with saturation.
// Depends on ekj_pkg for widths, constants and the quotient struct.
module ekj_divider (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [63:0] num,
    input  ekj_pkg::entry_t    den,
    output ekj_pkg::ekj_quot_t quot
);
    import ekj_pkg::*;

    localparam int DD_W = ENTRY_W + 14;

    logic [DD_W-1:0]      rem_reg [QUOT_BITS+1];
    logic [DD_W-1:0]      dd_reg  [QUOT_BITS+1];
    logic [QUOT_BITS-1:0] low_reg [QUOT_BITS+1];
    logic [QUOT_BITS-1:0] q_reg   [QUOT_BITS+1];
    logic [QUOT_BITS:0]   neg_reg;
    logic [QUOT_BITS:0]   nz_reg;
    logic [QUOT_BITS:0]   ovf_reg;

    logic [63:0]          un_next;
    logic [ENTRY_W-1:0]   ud_next;
    logic [63:0]          n_next;
    logic [DD_W-1:0]      dd_next;
    logic [QUOT_BITS-1:0] lim_next;
    logic                 sat_next;
    ekj_quot_t            quot_reg;

    // Magnitudes, rounding offset and the early check for a quotient too wide.
    always_comb begin
        un_next = num[63] ? 64'(-num) : 64'(num);
        ud_next = den[ENTRY_W-1] ? ENTRY_W'(-den) : ENTRY_W'(den);
        dd_next = {ud_next, 14'b0};
        n_next  = un_next + {19'b0, ud_next, 13'b0};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= {15'b0, n_next[63:33]};
            low_reg[0] <= n_next[32:0];
            dd_reg[0]  <= dd_next;
            q_reg[0]   <= '0;
            neg_reg[0] <= num[63] ^ den[ENTRY_W-1];
            nz_reg[0]  <= (un_next != 64'd0);
            ovf_reg[0] <= ({15'b0, n_next[63:33]} >= dd_next);
        end
    end

    // One quotient bit per stage.
    for (genvar j = 0; j < QUOT_BITS; j++) begin : g_bit
        logic [DD_W:0]   trial;
        logic [DD_W-1:0] rem_next;
        logic            bit_next;

        always_comb begin
            trial = {rem_reg[j], low_reg[j][QUOT_BITS-1]};
            if (trial >= {1'b0, dd_reg[j]}) begin
                rem_next = DD_W'(trial - {1'b0, dd_reg[j]});
                bit_next = 1'b1;
            end else begin
                rem_next = trial[DD_W-1:0];
                bit_next = 1'b0;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j+1] <= rem_next;
                low_reg[j+1] <= {low_reg[j][QUOT_BITS-2:0], 1'b0};
                q_reg[j+1]   <= {q_reg[j][QUOT_BITS-2:0], bit_next};
                dd_reg[j+1]  <= dd_reg[j];
                neg_reg[j+1] <= neg_reg[j];
                nz_reg[j+1]  <= nz_reg[j];
                ovf_reg[j+1] <= ovf_reg[j];
            end
        end
    end

    // Clip to the signed range and apply the sign; a zero numerator gives zero.
    always_comb begin
        lim_next = neg_reg[QUOT_BITS] ? 33'h080000000 : 33'h07fffffff;
        sat_next = nz_reg[QUOT_BITS] &&
                   (ovf_reg[QUOT_BITS] || (q_reg[QUOT_BITS] > lim_next));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quot_reg.sat <= sat_next;
            if (!nz_reg[QUOT_BITS]) begin
                quot_reg.value <= ZERO_Q16;
            end else if (sat_next) begin
                quot_reg.value <= neg_reg[QUOT_BITS] ? 32'sh80000000 : 32'sh7fffffff;
            end else if (neg_reg[QUOT_BITS]) begin
                quot_reg.value <= -$signed(q_reg[QUOT_BITS][ENTRY_W-1:0]);
            end else begin
                quot_reg.value <= $signed(q_reg[QUOT_BITS][ENTRY_W-1:0]);
            end
        end
    end

    assign quot = quot_reg;

endmodule

// File: rtl/euler_kinematic_jacobian_unit.sv
// Top level of the Euler kinematic Jacobian unit: CORDIC, products, quotients, row output.
// Depends on ekj_pkg, ekj_cordic and ekj_divider.
//
// Each accepted angle triple (roll, pitch, yaw) yields six result transactions, rows 0 to 5
// of the block-diagonal 6x6 kinematic matrix in signed Q15.16, row 5 flagged as last.
// The datapath is a 62-stage pipeline (26 CORDIC stages, one product stage, 35 divider
// stages) that takes a triple in every cycle unless stalled. The output register hands
// out one row per cycle while m_ready is high; while it holds rows not yet taken the
// whole pipeline stalls, so a new triple enters only as the last row is taken or the
// register is empty, and no data is lost or repeated.
module euler_kinematic_jacobian_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [ekj_pkg::ANGLE_W-1:0] s_roll_angle,
    input  logic signed [ekj_pkg::ANGLE_W-1:0] s_pitch_angle,
    input  logic signed [ekj_pkg::ANGLE_W-1:0] s_yaw_angle,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [ekj_pkg::ROW_W-1:0]          m_row_index,
    output ekj_pkg::entry_t                    m_entry_first,
    output ekj_pkg::entry_t                    m_entry_second,
    output ekj_pkg::entry_t                    m_entry_third,
    output logic                               m_saturated,
    output logic                               m_last_row
);
    import ekj_pkg::*;

    logic                  adv;
    logic [PIPE_DEPTH-1:0] vld_reg;
    entry_t                sf, cf, st, ct, sp, cp;

    // Product stage.
    entry_t             ctcp_a_reg, ctsp_a_reg, sfst_a_reg, cfst_a_reg, sfct_a_reg;
    entry_t             cfct_a_reg, cfsp_a_reg, cfcp_a_reg, sfsp_a_reg, sfcp_a_reg;
    entry_t             sf_a_reg, cf_a_reg, st_a_reg, ct_a_reg, sp_a_reg, cp_a_reg;
    logic signed [63:0] n3a_a_reg, n3b_a_reg;

    // Second product stage.
    entry_t sfstcp_b_reg, sfstsp_b_reg, cfstcp_b_reg, cfstsp_b_reg;
    entry_t ctcp_b_reg, ctsp_b_reg, st_b_reg, cfsp_b_reg, cfcp_b_reg;
    entry_t sfsp_b_reg, sfcp_b_reg, sfct_b_reg, cfct_b_reg, cf_b_reg, sf_b_reg;

    ekj_rows_t rows_next;
    ekj_rows_t dly_reg [ROWS_DEPTH];
    ekj_quot_t q3a, q3b, q5a, q5b;

    // Output register.
    logic               full_reg, full_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    ekj_rows_t          out_rows_reg;
    ekj_quot_t          out_q3a_reg, out_q3b_reg, out_q5a_reg, out_q5b_reg;

    // The whole pipeline moves when the output register is free or finishes this cycle.
    assign adv     = !full_reg || (m_ready && (row_reg == ROW_SEC));
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], s_valid};
        end
    end

    // Sine and cosine of the three angles.
    ekj_cordic u_cordic_roll (
        .aclk(aclk), .en(adv), .angle(s_roll_angle), .sin_out(sf), .cos_out(cf)
    );
    ekj_cordic u_cordic_pitch (
        .aclk(aclk), .en(adv), .angle(s_pitch_angle), .sin_out(st), .cos_out(ct)
    );
    ekj_cordic u_cordic_yaw (
        .aclk(aclk), .en(adv), .angle(s_yaw_angle), .sin_out(sp), .cos_out(cp)
    );

    // First products and the full-width numerators of the tangent row.
    always_ff @(posedge aclk) begin
        if (adv) begin
            ctcp_a_reg <= mul30(ct, cp);
            ctsp_a_reg <= mul30(ct, sp);
            sfst_a_reg <= mul30(sf, st);
            cfst_a_reg <= mul30(cf, st);
            sfct_a_reg <= mul30(sf, ct);
            cfct_a_reg <= mul30(cf, ct);
            cfsp_a_reg <= mul30(cf, sp);
            cfcp_a_reg <= mul30(cf, cp);
            sfsp_a_reg <= mul30(sf, sp);
            sfcp_a_reg <= mul30(sf, cp);
            n3a_a_reg  <= 64'(sf) * 64'(st);
            n3b_a_reg  <= 64'(cf) * 64'(st);
            sf_a_reg   <= sf;
            cf_a_reg   <= cf;
            st_a_reg   <= st;
            ct_a_reg   <= ct;
            sp_a_reg   <= sp;
            cp_a_reg   <= cp;
        end
    end

    // Three-factor products of the rotation block.
    always_ff @(posedge aclk) begin
        if (adv) begin
            sfstcp_b_reg <= mul30(sfst_a_reg, cp_a_reg);
            sfstsp_b_reg <= mul30(sfst_a_reg, sp_a_reg);
            cfstcp_b_reg <= mul30(cfst_a_reg, cp_a_reg);
            cfstsp_b_reg <= mul30(cfst_a_reg, sp_a_reg);
            ctcp_b_reg   <= ctcp_a_reg;
            ctsp_b_reg   <= ctsp_a_reg;
            st_b_reg     <= st_a_reg;
            cfsp_b_reg   <= cfsp_a_reg;
            cfcp_b_reg   <= cfcp_a_reg;
            sfsp_b_reg   <= sfsp_a_reg;
            sfcp_b_reg   <= sfcp_a_reg;
            sfct_b_reg   <= sfct_a_reg;
            cfct_b_reg   <= cfct_a_reg;
            cf_b_reg     <= cf_a_reg;
            sf_b_reg     <= sf_a_reg;
        end
    end

    // Sums and conversion to Q15.16.
    always_comb begin
        rows_next.r00 = toq16(CORDIC_W'(ctcp_b_reg));
        rows_next.r01 = toq16(CORDIC_W'(ctsp_b_reg));
        rows_next.r02 = toq16(-CORDIC_W'(st_b_reg));
        rows_next.r10 = toq16(CORDIC_W'(sfstcp_b_reg) - CORDIC_W'(cfsp_b_reg));
        rows_next.r11 = toq16(CORDIC_W'(sfstsp_b_reg) + CORDIC_W'(cfcp_b_reg));
        rows_next.r12 = toq16(CORDIC_W'(sfct_b_reg));
        rows_next.r20 = toq16(CORDIC_W'(cfstcp_b_reg) + CORDIC_W'(sfsp_b_reg));
        rows_next.r21 = toq16(CORDIC_W'(cfstsp_b_reg) - CORDIC_W'(sfcp_b_reg));
        rows_next.r22 = toq16(CORDIC_W'(cfct_b_reg));
        rows_next.r41 = toq16(CORDIC_W'(cf_b_reg));
        rows_next.r42 = toq16(-CORDIC_W'(sf_b_reg));
    end

    // Hold the product rows until the quotients catch up.
    always_ff @(posedge aclk) begin
        if (adv) begin
            dly_reg[0] <= rows_next;
            for (int k = 1; k < ROWS_DEPTH; k++) begin
                dly_reg[k] <= dly_reg[k-1];
            end
        end
    end

    // Tangent and secant terms, all divided by the cosine of pitch.
    ekj_divider u_div_3a (
        .aclk(aclk), .en(adv), .num(n3a_a_reg), .den(ct_a_reg), .quot(q3a)
    );
    ekj_divider u_div_3b (
        .aclk(aclk), .en(adv), .num(n3b_a_reg), .den(ct_a_reg), .quot(q3b)
    );
    ekj_divider u_div_5a (
        .aclk(aclk), .en(adv),
        .num({{2{sf_a_reg[ENTRY_W-1]}}, sf_a_reg, 30'b0}), .den(ct_a_reg), .quot(q5a)
    );
    ekj_divider u_div_5b (
        .aclk(aclk), .en(adv),
        .num({{2{cf_a_reg[ENTRY_W-1]}}, cf_a_reg, 30'b0}), .den(ct_a_reg), .quot(q5b)
    );

    // Output register: loads a whole matrix, then steps through its rows.
    always_comb begin
        full_next = full_reg;
        row_next  = row_reg;
        if (adv) begin
            full_next = vld_reg[PIPE_DEPTH-1];
            row_next  = ROW_FIRST;
        end else if (full_reg && m_ready) begin
            row_next = row_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= 1'b0;
            row_reg  <= ROW_FIRST;
        end else begin
            full_reg <= full_next;
            row_reg  <= row_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_rows_reg <= dly_reg[ROWS_DEPTH-1];
            out_q3a_reg  <= q3a;
            out_q3b_reg  <= q3b;
            out_q5a_reg  <= q5a;
            out_q5b_reg  <= q5b;
        end
    end

    // Row selection.
    always_comb begin
        m_saturated = 1'b0;
        case (row_reg)
            ROW_FIRST: begin
                m_entry_first  = out_rows_reg.r00;
                m_entry_second = out_rows_reg.r01;
                m_entry_third  = out_rows_reg.r02;
            end
            ROW_R1: begin
                m_entry_first  = out_rows_reg.r10;
                m_entry_second = out_rows_reg.r11;
                m_entry_third  = out_rows_reg.r12;
            end
            ROW_R2: begin
                m_entry_first  = out_rows_reg.r20;
                m_entry_second = out_rows_reg.r21;
                m_entry_third  = out_rows_reg.r22;
            end
            ROW_TAN: begin
                m_entry_first  = ONE_Q16;
                m_entry_second = out_q3a_reg.value;
                m_entry_third  = out_q3b_reg.value;
                m_saturated    = out_q3a_reg.sat | out_q3b_reg.sat;
            end
            ROW_RATE: begin
                m_entry_first  = ZERO_Q16;
                m_entry_second = out_rows_reg.r41;
                m_entry_third  = out_rows_reg.r42;
            end
            default: begin
                m_entry_first  = ZERO_Q16;
                m_entry_second = out_q5a_reg.value;
                m_entry_third  = out_q5b_reg.value;
                m_saturated    = out_q5a_reg.sat | out_q5b_reg.sat;
            end
        endcase
    end

    assign m_valid     = full_reg;
    assign m_row_index = row_reg;
    assign m_last_row  = (row_reg == ROW_SEC);

    // The row counter never leaves the six rows of a matrix.
    a_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        row_reg <= ROW_SEC)
        else $error("row counter out of range");

    // Rows of one matrix come out in order.
    a_row_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_row |=>
            m_valid && (m_row_index == $past(m_row_index) + 3'd1))
        else $error("row sequence broken");

    // A new matrix starts at row zero.
    a_row_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last_row |=> !m_valid || (m_row_index == ROW_FIRST))
        else $error("matrix did not restart at row zero");

    // Only the quotient rows can clip.
    a_sat_rows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |-> (m_row_index == ROW_TAN) || (m_row_index == ROW_SEC))
        else $error("saturation flagged on a row without quotients");

    // A stalled pipeline keeps its valid bits.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |=> $stable(vld_reg))
        else $error("pipeline moved during a stall");

endmodule

// File: verif/tb.sv
// Self-checking testbench for euler_kinematic_jacobian_unit: predicts all six matrix rows per
// angle triple and compares them with the result transactions. Depends on ekj_pkg and the RTL.
module tb;
    import ekj_pkg::*;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
    } angles_t;

    typedef struct packed {
        logic [2:0] row;
        entry_t     e1;
        entry_t     e2;
        entry_t     e3;
        logic       sat;
        logic       last;
    } row_t;

    localparam int CYCLE_LIMIT = 400000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [15:0] s_roll_angle = '0;
    logic signed [15:0] s_pitch_angle = '0;
    logic signed [15:0] s_yaw_angle = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [2:0] m_row_index;
    entry_t m_entry_first, m_entry_second, m_entry_third;
    logic m_saturated, m_last_row;

    angles_t pending_angles[$];
    row_t    expected_rows[$];
    int      errors = 0;
    int      rows_seen = 0;
    int      triples_sent = 0;
    int      cycles = 0;
    bit      calm = 1'b0;
    bit      in_taken = 1'b0;
    int      send_hold = 0;
    int      recv_hold = 0;

    euler_kinematic_jacobian_unit i_dut (.*);

    // Clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Floor shift of a signed 64-bit value.
    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    // Queue helpers.
    function automatic void add_row(row_t r);
        expected_rows.insert(expected_rows.size(), r);
    endfunction

    function automatic void add_angles(angles_t a);
        pending_angles.insert(pending_angles.size(), a);
    endfunction

    // Rotation-mode CORDIC on a folded binary angle, Q30 results.
    function automatic void sin_cos(input logic signed [15:0] ang,
                                    output longint s, output longint c);
        longint a, x, y, z, t;
        bit flip;
        a = ang;
        flip = 1'b0;
        if (a > 16384) begin
            a = a - 32768;
            flip = 1'b1;
        end else if (a < -16384) begin
            a = a + 32768;
            flip = 1'b1;
        end
        x = 652032874;
        y = 0;
        z = a * 65536;
        for (int i = 0; i < 24; i++) begin
            if (z >= 0) begin
                t = x - fshr(y, i);
                y = y + fshr(x, i);
                z = z - longint'(ATAN_TAB[i]);
            end else begin
                t = x + fshr(y, i);
                y = y - fshr(x, i);
                z = z + longint'(ATAN_TAB[i]);
            end
            x = t;
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic longint q30_mul(longint a, longint b);
        return fshr(a * b, 30);
    endfunction

    function automatic entry_t q30_to_q16(longint v);
        longint r;
        r = fshr(v + 8192, 14);
        return entry_t'(r);
    endfunction

    // Rounded Q60/Q30 quotient in Q15.16, clipped with a flag.
    function automatic entry_t ratio_q16(longint n, longint d, inout logic sat);
        bit neg;
        longint unsigned un, ud, den, q, lim;
        neg = (n < 0) != (d < 0);
        un = (n < 0) ? -n : n;
        ud = (d < 0) ? -d : d;
        if (un == 0) return '0;
        lim = neg ? 64'd2147483648 : 64'd2147483647;
        if (ud == 0) begin
            sat = 1'b1;
            return neg ? entry_t'(-longint'(lim)) : entry_t'(lim);
        end
        den = ud << 14;
        q = (un + den / 2) / den;
        if (q > lim) begin
            q = lim;
            sat = 1'b1;
        end
        return neg ? entry_t'(-longint'(q)) : entry_t'(q);
    endfunction

    // Queue the six rows of the kinematic matrix for one triple.
    task automatic predict_matrix(angles_t a);
        longint sf, cf, st, ct, sp, cp;
        logic s3, s5;
        entry_t q1, q2;
        s3 = 1'b0;
        s5 = 1'b0;
        sin_cos(a.roll, sf, cf);
        sin_cos(a.pitch, st, ct);
        sin_cos(a.yaw, sp, cp);
        add_row('{ROW_FIRST, q30_to_q16(q30_mul(ct, cp)),
            q30_to_q16(q30_mul(ct, sp)), q30_to_q16(-st), 1'b0, 1'b0});
        add_row('{ROW_R1,
            q30_to_q16(q30_mul(q30_mul(sf, st), cp) - q30_mul(cf, sp)),
            q30_to_q16(q30_mul(q30_mul(sf, st), sp) + q30_mul(cf, cp)),
            q30_to_q16(q30_mul(sf, ct)), 1'b0, 1'b0});
        add_row('{ROW_R2,
            q30_to_q16(q30_mul(q30_mul(cf, st), cp) + q30_mul(sf, sp)),
            q30_to_q16(q30_mul(q30_mul(cf, st), sp) - q30_mul(sf, cp)),
            q30_to_q16(q30_mul(cf, ct)), 1'b0, 1'b0});
        q1 = ratio_q16(sf * st, ct, s3);
        q2 = ratio_q16(cf * st, ct, s3);
        add_row('{ROW_TAN, ONE_Q16, q1, q2, s3, 1'b0});
        add_row('{ROW_RATE, ZERO_Q16, q30_to_q16(cf),
            q30_to_q16(-sf), 1'b0, 1'b0});
        q1 = ratio_q16(sf * 1073741824, ct, s5);
        q2 = ratio_q16(cf * 1073741824, ct, s5);
        add_row('{ROW_SEC, ZERO_Q16, q1, q2, s5, 1'b1});
    endtask

    // Directed corners, then mostly random angles with some near vertical pitch.
    initial begin
        logic signed [15:0] corner[9] = '{16'sh8000, 16'sh7fff, 16'sd0, 16'sd16384,
            -16'sd16384, 16'sd16383, 16'sd16385, -16'sd16385, 16'sd1};
        angles_t a;
        foreach (corner[i]) add_angles('{corner[i], corner[i], corner[i]});
        for (int i = 0; i < 9; i++)
            add_angles('{corner[(i + 3) % 9], corner[i], corner[(i + 5) % 9]});
        add_angles('{16'sh7fff, 16'sd16384, 16'sh8000});
        add_angles('{16'sh5555, -16'sd16384, 16'shaaaa});
        for (int i = 0; i < 230; i++) begin
            a.roll = 16'($urandom);
            a.yaw = 16'($urandom);
            if ($urandom_range(0, 4) == 0)
                a.pitch = ($urandom_range(0, 1) ? 16'sd16384 : -16'sd16384)
                          + $signed(16'($urandom_range(0, 6))) - 16'sd3;
            else
                a.pitch = 16'($urandom);
            add_angles(a);
        end
    end

    // Driver: offers triples from the queue, with random gaps.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || in_taken) begin
                if (send_hold > 0) begin
                    send_hold <= send_hold - 1;
                    s_valid <= 1'b0;
                end else if (pending_angles.size() > 0) begin
                    s_roll_angle <= pending_angles[0].roll;
                    s_pitch_angle <= pending_angles[0].pitch;
                    s_yaw_angle <= pending_angles[0].yaw;
                    s_valid <= 1'b1;
                    pending_angles.pop_front();
                    if (!calm && $urandom_range(0, 7) == 0)
                        send_hold <= $urandom_range(1, 16);
                end else begin
                    s_valid <= 1'b0;
                end
            end
            // Receiver stalls in bursts.
            if (recv_hold > 0) begin
                recv_hold <= recv_hold - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!calm && $urandom_range(0, 9) == 0)
                    recv_hold <= $urandom_range(1, 16);
            end
            calm <= pending_angles.size() < 30;
        end
    end

    // Input monitor predicts; output monitor checks each row.
    always @(posedge aclk) begin
        row_t got, want;
        int bad;
        bad = 0;
        cycles <= cycles + 1;
        in_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            predict_matrix('{s_roll_angle, s_pitch_angle, s_yaw_angle});
            triples_sent <= triples_sent + 1;
        end
        if (aresetn && m_valid && m_ready) begin
            got = '{m_row_index, m_entry_first, m_entry_second, m_entry_third,
                    m_saturated, m_last_row};
            rows_seen <= rows_seen + 1;
            if (expected_rows.size() == 0) begin
                $error("row with no prediction: row_index %0d", got.row);
                bad++;
            end else begin
                want = expected_rows.pop_front();
                if (got.row !== want.row) begin
                    $error("row_index expected %0d got %0d", want.row, got.row);
                    bad++;
                end
                if (got.e1 !== want.e1) begin
                    $error("entry_first expected %0d got %0d", want.e1, got.e1);
                    bad++;
                end
                if (got.e2 !== want.e2) begin
                    $error("entry_second expected %0d got %0d", want.e2, got.e2);
                    bad++;
                end
                if (got.e3 !== want.e3) begin
                    $error("entry_third expected %0d got %0d", want.e3, got.e3);
                    bad++;
                end
                if (got.sat !== want.sat) begin
                    $error("saturated expected %0d got %0d", want.sat, got.sat);
                    bad++;
                end
                if (got.last !== want.last) begin
                    $error("last_row expected %0d got %0d", want.last, got.last);
                    bad++;
                end
            end
            if (bad > 0)
                errors <= errors + bad;
        end
    end

    // Reset, completion and timeout.
    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        fork
            begin
                wait (pending_angles.size() == 0 && !s_valid && expected_rows.size() == 0);
                repeat (PIPE_DEPTH + 20) @(posedge aclk);
            end
            begin
                wait (cycles >= CYCLE_LIMIT);
                $display("Timeout after %0d cycles", cycles);
                $display("Some tests failed");
                $finish;
            end
        join_any
        $display("Sent %0d angle triples and checked %0d matrix rows, %0d mismatches.",
                 triples_sent, rows_seen, errors);
        if (errors == 0 && expected_rows.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
